// File: rtl/pkfa_pkg.sv
`default_nettype none
package pkfa_pkg;

   localparam int unsigned FIELD_IDX_W = 13;
   localparam int unsigned SPLIT_W     = 14;
   localparam int unsigned ACC_W       = 48;
   localparam int unsigned TERM_W      = 40;

   typedef enum logic [1:0] {
      ACT_LOAD     = 2'd0,
      ACT_INTEGRAL = 2'd1,
      ACT_READ     = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_WEIGHT_LOW  = 2'd0,
      CSR_WEIGHT_EXCH = 2'd1,
      CSR_WEIGHT_HIGH = 2'd2,
      CSR_SPLIT       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]             action;
      logic [FIELD_IDX_W-1:0] first_index;
      logic [FIELD_IDX_W-1:0] second_index;
      logic signed [31:0]     coulomb_value;
      logic signed [31:0]     exchange_value;
      logic signed [31:0]     density_closed;
      logic signed [31:0]     density_open;
      logic                   open_flag;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] g_value;
      logic signed [ACC_W-1:0] go_value;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] closed;
      logic signed [31:0] open;
      logic               mask;
   } dens_word_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] closed;
      logic signed [ACC_W-1:0] open;
   } acc_word_type;

   // Q16.48 product to 24 fraction bits, rounding half up.
   function automatic logic signed [TERM_W-1:0] round24(input logic signed [63:0] x);
      logic signed [63:0] s;
      s = x + 64'sd8388608;
      return s[63:24];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [TERM_W:0] x);
      logic signed [TERM_W:0] hi;
      logic signed [TERM_W:0] lo;
      hi = (TERM_W+1)'(64'sh7FFFFFFF);
      lo = -hi - 1;
      if (x > hi) return 32'sh7FFFFFFF;
      if (x < lo) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [TERM_W-1:0] t);
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + (ACC_W+1)'(t);
      if (s[ACC_W] != s[ACC_W-1]) return {s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
      return s[ACC_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/pk_integral_fock_accumulate_core.sv
`default_nettype none
// Builds closed- and open-shell two-electron matrices in two on-chip memories (densities and
// accumulators, MAX_PAIRS entries each, MAX_PAIRS a power of two). A load word writes both
// memories as it is accepted, a read word may wait on rsp_stall, and in an integral word
// its five products go one after another through a single 32x32 multiplier, and its
// two accumulator updates are read-modify-writes on one memory port pair. One word is
// worked on at a time. Entries must be loaded before they are used or read.
module pk_integral_fock_accumulate_core #(
   parameter int unsigned MAX_PAIRS = 8192
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire pkfa_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output pkfa_pkg::rsp_type    rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [31:0]     csr_data
);
   localparam int unsigned IDX_W = $clog2(MAX_PAIRS);
   localparam int unsigned DENS_W = $bits(pkfa_pkg::dens_word_type);
   localparam int unsigned ACCW_W = $bits(pkfa_pkg::acc_word_type);

   typedef enum logic [3:0] {
      S_IDLE, S_RDIJ, S_COEF, S_M2, S_M3, S_M4, S_M5, S_M6, S_RDOUT
   } state_type;

   state_type state_ff;
   logic signed [31:0] w_low_ff, w_exch_ff, w_high_ff;
   logic [pkfa_pkg::SPLIT_W-1:0] split_ff;
   pkfa_pkg::req_type item_ff;
   pkfa_pkg::dens_word_type dkl_ff, dij_ff;
   logic signed [31:0] coef_ff;
   logic signed [63:0] prod_ff;
   logic signed [pkfa_pkg::TERM_W-1:0] tc_ij_ff, tc_kl_ff, to_ij_ff, to_kl_ff;
   pkfa_pkg::acc_word_type new_ij_ff;
   logic rsp_valid_ff;
   pkfa_pkg::rsp_type rsp_data_ff;

   logic accept;
   logic [IDX_W-1:0] ij, kl, req_ij;
   logic region_low, region_mid, open_both;
   logic signed [31:0] mul_a, mul_b;
   logic signed [31:0] coef_in;
   logic dens_we, dens_re, acc_we, acc_re;
   logic [IDX_W-1:0] dens_raddr, acc_waddr, acc_raddr;
   pkfa_pkg::dens_word_type dens_wdata, dens_rdata;
   pkfa_pkg::acc_word_type acc_wdata, acc_rdata, acc_base, acc_sum;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign req_ij = IDX_W'(req_data.first_index);
   assign ij = IDX_W'(item_ff.first_index);
   assign kl = IDX_W'(item_ff.second_index);

   assign region_low = {1'b0, item_ff.first_index} < split_ff;
   assign region_mid = !region_low && ({1'b0, item_ff.second_index} < split_ff);
   assign open_both = dkl_ff.mask && dij_ff.mask;

   always_comb begin
      mul_a = item_ff.coulomb_value;
      mul_b = w_high_ff;
      unique case (state_ff)
         S_RDIJ: begin
            if (region_low) begin
               mul_b = w_low_ff;
            end else if (region_mid) begin
               mul_a = item_ff.exchange_value;
               mul_b = w_exch_ff;
            end
         end
         S_COEF: mul_b = dkl_ff.closed;
         S_M2: mul_b = dij_ff.closed;
         S_M3: begin
            mul_a = coef_ff;
            mul_b = dkl_ff.open;
         end
         S_M4: begin
            mul_a = coef_ff;
            mul_b = dij_ff.open;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (region_mid) begin
         coef_in = pkfa_pkg::sat32(
            (pkfa_pkg::TERM_W+1)'(item_ff.coulomb_value)
            + (pkfa_pkg::TERM_W+1)'(pkfa_pkg::sat32(
               (pkfa_pkg::TERM_W+1)'(pkfa_pkg::round24(prod_ff)))));
      end else begin
         coef_in = pkfa_pkg::sat32((pkfa_pkg::TERM_W+1)'(pkfa_pkg::round24(prod_ff)));
      end
   end

   // When both indices match, the second update builds on the first one just written.
   always_comb begin
      acc_base = acc_rdata;
      if (state_ff == S_M6 && kl == ij) begin
         acc_base = new_ij_ff;
      end
      if (state_ff == S_M6) begin
         acc_sum.closed = pkfa_pkg::acc_add(acc_base.closed, tc_kl_ff);
         acc_sum.open = pkfa_pkg::acc_add(acc_base.open, to_kl_ff);
      end else begin
         acc_sum.closed = pkfa_pkg::acc_add(acc_base.closed, tc_ij_ff);
         acc_sum.open = pkfa_pkg::acc_add(acc_base.open, to_ij_ff);
      end
   end

   always_comb begin
      dens_we = accept && (req_data.action == pkfa_pkg::ACT_LOAD);
      dens_wdata.closed = req_data.density_closed;
      dens_wdata.open = req_data.density_open;
      dens_wdata.mask = req_data.open_flag;
      dens_re = 1'b0;
      dens_raddr = IDX_W'(req_data.second_index);
      acc_we = 1'b0;
      acc_waddr = ij;
      acc_wdata = acc_sum;
      acc_re = 1'b0;
      acc_raddr = ij;
      unique case (state_ff)
         S_IDLE: begin
            dens_re = accept && (req_data.action == pkfa_pkg::ACT_INTEGRAL);
            acc_re = accept && (req_data.action == pkfa_pkg::ACT_READ);
            acc_raddr = req_ij;
            acc_we = dens_we;
            acc_waddr = req_ij;
            acc_wdata = '0;
         end
         S_RDIJ: begin
            dens_re = 1'b1;
            dens_raddr = ij;
         end
         S_M4: acc_re = 1'b1;
         S_M5: begin
            acc_we = 1'b1;
            acc_re = 1'b1;
            acc_raddr = kl;
         end
         S_M6: begin
            acc_we = 1'b1;
            acc_waddr = kl;
         end
         default: ;
      endcase
   end

   pkfa_ram #(.WIDTH(DENS_W), .DEPTH(MAX_PAIRS)) u_dens (
      .clock(clock), .wr_en(dens_we), .wr_addr(req_ij), .wr_data(dens_wdata),
      .rd_en(dens_re), .rd_addr(dens_raddr), .rd_data(dens_rdata)
   );

   pkfa_ram #(.WIDTH(ACCW_W), .DEPTH(MAX_PAIRS)) u_acc (
      .clock(clock), .wr_en(acc_we), .wr_addr(acc_waddr), .wr_data(acc_wdata),
      .rd_en(acc_re), .rd_addr(acc_raddr), .rd_data(acc_rdata)
   );

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (accept) begin
         item_ff <= req_data;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         w_low_ff <= '0;
         w_exch_ff <= '0;
         w_high_ff <= '0;
         split_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (pkfa_pkg::csr_index_type'(csr_index))
               pkfa_pkg::CSR_WEIGHT_LOW:  w_low_ff <= csr_data;
               pkfa_pkg::CSR_WEIGHT_EXCH: w_exch_ff <= csr_data;
               pkfa_pkg::CSR_WEIGHT_HIGH: w_high_ff <= csr_data;
               pkfa_pkg::CSR_SPLIT:       split_ff <= csr_data[pkfa_pkg::SPLIT_W-1:0];
            endcase
         end
         // In the output state a taken word is replaced by the next one below.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_RDOUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_data.action == pkfa_pkg::ACT_INTEGRAL) begin
                  state_ff <= S_RDIJ;
               end else if (accept && req_data.action == pkfa_pkg::ACT_READ) begin
                  state_ff <= S_RDOUT;
               end
            end
            S_RDIJ: begin
               dkl_ff <= dens_rdata;
               state_ff <= S_COEF;
            end
            S_COEF: begin
               dij_ff <= dens_rdata;
               coef_ff <= coef_in;
               state_ff <= S_M2;
            end
            S_M2: begin
               tc_ij_ff <= pkfa_pkg::round24(prod_ff);
               state_ff <= S_M3;
            end
            S_M3: begin
               tc_kl_ff <= pkfa_pkg::round24(prod_ff);
               state_ff <= S_M4;
            end
            S_M4: begin
               to_ij_ff <= open_both ? pkfa_pkg::round24(prod_ff) : '0;
               state_ff <= S_M5;
            end
            S_M5: begin
               to_kl_ff <= open_both ? pkfa_pkg::round24(prod_ff) : '0;
               new_ij_ff <= acc_sum;
               state_ff <= S_M6;
            end
            S_M6: state_ff <= S_IDLE;
            S_RDOUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.g_value <= acc_rdata.closed;
                  rsp_data_ff.go_value <= acc_rdata.open;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_read_goes_out: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == pkfa_pkg::ACT_READ |=> state_ff == S_RDOUT)
      else $error("read word did not move to output state");

   a_load_writes_both: assert property (@(posedge clock) disable iff (reset)
      dens_we |-> acc_we && acc_waddr == req_ij)
      else $error("load word did not clear accumulators");

   a_integral_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_M6 |-> $past(state_ff, 1) == S_M5)
      else $error("integral sequence broken");
`endif
endmodule
`default_nettype wire

// File: rtl/pkfa_ram.sv
`default_nettype none
module pkfa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: tb/sv/pk_integral_fock_accumulate_core_test.sv
`default_nettype none
module pk_integral_fock_accumulate_core_test;

   localparam int NPAIRS      = 8192;
   localparam int WATCH_LIMIT = 20000;
   localparam int QUIET_WAIT  = 40;
   localparam logic signed [63:0] ACC_HI = 64'sd140737488355327;
   localparam logic signed [63:0] ACC_LO = -64'sd140737488355328;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   pkfa_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   pkfa_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   pk_integral_fock_accumulate_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: densities, flags and both accumulators.
   logic signed [63:0] wt_low, wt_exch, wt_high;
   logic [13:0]        split_bound;
   logic signed [63:0] dens_c [NPAIRS];
   logic signed [63:0] dens_o [NPAIRS];
   logic               flag_o [NPAIRS];
   logic signed [63:0] fock_c [NPAIRS];
   logic signed [63:0] fock_o [NPAIRS];
   bit                 loaded [NPAIRS];
   pkfa_pkg::rsp_type  pending_reads[$];
   int                 mismatches = 0;
   bit                 timed_out = 0;
   bit                 stall_free = 0;
   int                 idle_cycles = 0;
   int                 loaded_list[$];

   function automatic logic signed [63:0] rnd24(input logic signed [63:0] x);
      return (x + 64'sd8388608) >>> 24;
   endfunction

   function automatic logic signed [63:0] clip32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic logic signed [63:0] clip48(input logic signed [63:0] x);
      if (x > ACC_HI) return ACC_HI;
      if (x < ACC_LO) return ACC_LO;
      return x;
   endfunction

   task automatic apply_word(input pkfa_pkg::req_type w);
      int ij, kl;
      logic signed [63:0] p, q, coef;
      ij = w.first_index;
      kl = w.second_index;
      p = w.coulomb_value;
      q = w.exchange_value;
      case (pkfa_pkg::action_type'(w.action))
         pkfa_pkg::ACT_LOAD: begin
            dens_c[ij] = w.density_closed;
            dens_o[ij] = w.density_open;
            flag_o[ij] = w.open_flag;
            fock_c[ij] = 0;
            fock_o[ij] = 0;
         end
         pkfa_pkg::ACT_INTEGRAL: begin
            fock_c[ij] = clip48(fock_c[ij] + rnd24(dens_c[kl] * p));
            fock_c[kl] = clip48(fock_c[kl] + rnd24(dens_c[ij] * p));
            if (flag_o[ij] && flag_o[kl]) begin
               if (ij < split_bound) coef = clip32(rnd24(wt_low * p));
               else if (kl < split_bound) coef = clip32(p + clip32(rnd24(wt_exch * q)));
               else coef = clip32(rnd24(wt_high * p));
               fock_o[ij] = clip48(fock_o[ij] + rnd24(dens_o[kl] * coef));
               fock_o[kl] = clip48(fock_o[kl] + rnd24(dens_o[ij] * coef));
            end
         end
         pkfa_pkg::ACT_READ: begin
            pkfa_pkg::rsp_type r;
            r.g_value  = fock_c[ij][47:0];
            r.go_value = fock_o[ij][47:0];
            pending_reads.push_back(r);
         end
         default: ;
      endcase
   endtask

   // Result checking and the idle watchdog.
   always @(posedge clock) begin
      pkfa_pkg::rsp_type exp_r;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_reads.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected read word %h", rsp_data);
            end else begin
               exp_r = pending_reads.pop_front();
               if (rsp_data.g_value !== exp_r.g_value ||
                   rsp_data.go_value !== exp_r.go_value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("read mismatch: g exp %h got %h, go exp %h got %h",
                              exp_r.g_value, rsp_data.g_value,
                              exp_r.go_value, rsp_data.go_value);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles > WATCH_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver stalls in bursts.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!stall_free && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_free) begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_write(input pkfa_pkg::csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pkfa_pkg::CSR_WEIGHT_LOW:  wt_low  = $signed(val);
         pkfa_pkg::CSR_WEIGHT_EXCH: wt_exch = $signed(val);
         pkfa_pkg::CSR_WEIGHT_HIGH: wt_high = $signed(val);
         default:                   split_bound = val[13:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Valid stays high from one word to the next unless a gap is taken.
   task automatic send_word(input pkfa_pkg::req_type w, input bit gaps);
      int n;
      @(negedge clock);
      if (gaps && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      apply_word(w);
      if (w.action == pkfa_pkg::ACT_LOAD && !loaded[w.first_index]) begin
         loaded[w.first_index] = 1;
         loaded_list.push_back(w.first_index);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h01FFFFFF);
         3: return -$urandom_range(0, 32'h01FFFFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [12:0] pick_loaded();
      return 13'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
   endfunction

   function automatic logic [12:0] rand_entry();
      case ($urandom_range(0, 3))
         0: return 13'($urandom_range(0, 15));
         1: return 13'($urandom_range(8176, 8191));
         default: return 13'($urandom);
      endcase
   endfunction

   typedef struct {
      pkfa_pkg::action_type act;
      logic [12:0]        a;
      logic [12:0]        b;
      logic [31:0]        p;
      logic [31:0]        q;
      logic [31:0]        dc;
      logic [31:0]        dop;
      logic               fl;
      bit                 known;
      logic signed [47:0] g_exp;
      logic signed [47:0] go_exp;
   } stim_row;

   stim_row directed[] = '{
      '{pkfa_pkg::ACT_LOAD,     13'd0,    13'd0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000,
        1'b1, 0, 0, 0},
      '{pkfa_pkg::ACT_READ,     13'd0,    13'd0, 32'h0, 32'h0, 32'h0, 32'h0,
        1'b0, 1, 48'sd0, 48'sd0},
      '{pkfa_pkg::ACT_LOAD,     13'd8191, 13'd0, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF,
        1'b1, 0, 0, 0},
      '{pkfa_pkg::ACT_LOAD,     13'd5,    13'd0, 32'h0, 32'h0, 32'h01000000, 32'h01000000,
        1'b0, 0, 0, 0},
      '{pkfa_pkg::ACT_INTEGRAL, 13'd0,    13'd8191, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0,
        1'b0, 0, 0, 0},
      '{pkfa_pkg::ACT_INTEGRAL, 13'd8191, 13'd0, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0,
        1'b0, 0, 0, 0},
      '{pkfa_pkg::ACT_INTEGRAL, 13'd0,    13'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0,
        1'b0, 0, 0, 0},
      '{pkfa_pkg::ACT_INTEGRAL, 13'd5,    13'd0, 32'h01000000, 32'h0, 32'h0, 32'h0,
        1'b0, 0, 0, 0},
      '{pkfa_pkg::ACT_INTEGRAL, 13'd5,    13'd5, 32'hFF000000, 32'h0, 32'h0, 32'h0,
        1'b0, 0, 0, 0},
      '{pkfa_pkg::ACT_NONE,     13'd5,    13'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 1'b1, 0, 0, 0},
      '{pkfa_pkg::ACT_READ,     13'd0,    13'd0, 32'h0, 32'h0, 32'h0, 32'h0,
        1'b0, 0, 0, 0},
      '{pkfa_pkg::ACT_READ,     13'd8191, 13'd0, 32'h0, 32'h0, 32'h0, 32'h0,
        1'b0, 0, 0, 0},
      '{pkfa_pkg::ACT_READ,     13'd5,    13'd0, 32'h0, 32'h0, 32'h0, 32'h0,
        1'b0, 0, 0, 0}
   };

   // Repeated accumulation: hammer one closed entry with maximal products.
   task automatic saturate_entry;
      pkfa_pkg::req_type w;
      w = '0;
      w.action = pkfa_pkg::ACT_INTEGRAL;
      w.first_index = 13'd0;
      w.second_index = 13'd0;
      w.coulomb_value = 32'sh7FFFFFFF;
      repeat (20) send_word(w, 0);
      w.action = pkfa_pkg::ACT_READ;
      send_word(w, 0);
   endtask

   initial begin
      pkfa_pkg::req_type w;
      pkfa_pkg::rsp_type exp_r;
      int k, r;
      wt_low = 0; wt_exch = 0; wt_high = 0; split_bound = 0;
      for (k = 0; k < NPAIRS; k++) begin
         dens_c[k] = 0; dens_o[k] = 0; flag_o[k] = 0;
         fock_c[k] = 0; fock_o[k] = 0; loaded[k] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(pkfa_pkg::CSR_WEIGHT_LOW,  32'h01000000);
      csr_write(pkfa_pkg::CSR_WEIGHT_EXCH, 32'h80000000);
      csr_write(pkfa_pkg::CSR_WEIGHT_HIGH, 32'h7FFFFFFF);
      csr_write(pkfa_pkg::CSR_SPLIT,       32'd4096);

      foreach (directed[i]) begin
         w = '0;
         w.action = directed[i].act;
         w.first_index = directed[i].a;
         w.second_index = directed[i].b;
         w.coulomb_value = directed[i].p;
         w.exchange_value = directed[i].q;
         w.density_closed = directed[i].dc;
         w.density_open = directed[i].dop;
         w.open_flag = directed[i].fl;
         send_word(w, 1);
         if (directed[i].known) begin
            exp_r = pending_reads[$];
            if (exp_r.g_value !== directed[i].g_exp || exp_r.go_value !== directed[i].go_exp)
            begin
               mismatches++;
               if (mismatches <= 10) $display("shadow disagrees with table row %0d", i);
            end
         end
      end
      saturate_entry();
      drain();

      // Random phases under several weight and split settings.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               csr_write(pkfa_pkg::CSR_SPLIT, 32'd0);
               csr_write(pkfa_pkg::CSR_WEIGHT_HIGH, 32'h80000000);
            end
            1: begin
               csr_write(pkfa_pkg::CSR_SPLIT, 32'd8192);
               csr_write(pkfa_pkg::CSR_WEIGHT_LOW, 32'h7FFFFFFF);
            end
            2: begin
               csr_write(pkfa_pkg::CSR_SPLIT, 32'($urandom_range(1, 8191)));
               csr_write(pkfa_pkg::CSR_WEIGHT_EXCH, rand_val());
            end
            default: begin
               csr_write(pkfa_pkg::CSR_WEIGHT_LOW, rand_val());
               csr_write(pkfa_pkg::CSR_WEIGHT_EXCH, rand_val());
               csr_write(pkfa_pkg::CSR_WEIGHT_HIGH, rand_val());
               csr_write(pkfa_pkg::CSR_SPLIT, 32'($urandom_range(0, 8192)));
            end
         endcase
         if (ph == 4) stall_free = 1;
         for (k = 0; k < 110; k++) begin
            w = '0;
            r = $urandom_range(0, 19);
            w.coulomb_value = rand_val();
            w.exchange_value = ($urandom_range(0, 3) == 0) ? 32'h0 : rand_val();
            w.density_closed = rand_val();
            w.density_open = rand_val();
            w.open_flag = $urandom_range(0, 3) != 0;
            w.second_index = 13'($urandom);
            if (r < 5 || loaded_list.size() < 2) begin
               w.action = pkfa_pkg::ACT_LOAD;
               w.first_index = rand_entry();
            end else if (r < 15) begin
               w.action = pkfa_pkg::ACT_INTEGRAL;
               w.first_index = pick_loaded();
               w.second_index = pick_loaded();
            end else if (r < 19) begin
               w.action = pkfa_pkg::ACT_READ;
               w.first_index = pick_loaded();
            end else begin
               w.action = pkfa_pkg::ACT_NONE;
               w.first_index = 13'($urandom);
            end
            send_word(w, ph != 4);
            if (ph == 2 && k == 50) begin
               drain();
            end
         end
         drain();
      end

      if (mismatches == 0 && pending_reads.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
rtl/pkfa_pkg.sv
rtl/pkfa_ram.sv
rtl/pk_integral_fock_accumulate_core.sv
tb/sv/pk_integral_fock_accumulate_core_test.sv
